### rtl/dcp_pkg.sv
// Package for the distance constraint projection block.
// Holds the payload structs, fixed widths and the saturation helper.
package dcp_pkg;

  localparam int unsigned SumW  = 68;
  localparam int unsigned RootW = 34;
  localparam int unsigned FracW = 30;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [23:0]        first_inv_mass;
    logic [23:0]        second_inv_mass;
    logic [30:0]        max_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_z;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_z;
    logic               corrected;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/dcp_in_if.sv
// Input channel interface: valid, ready and one constraint item.
// Depends on dcp_pkg.
interface dcp_in_if;
  logic          valid;
  logic          ready;
  dcp_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/dcp_out_if.sv
// Output channel interface: valid, ready and one corrected item.
// Depends on dcp_pkg.
interface dcp_out_if;
  logic          valid;
  logic          ready;
  dcp_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/dcp_delay.sv
// Enabled shift line that carries side data alongside a pipelined unit.
// No package dependencies.
module dcp_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < N; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[N-1];
endmodule

### rtl/dcp_isqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on dcp_pkg for the operand widths.
module dcp_isqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [dcp_pkg::SumW-1:0]  s_i,
  output logic [dcp_pkg::RootW-1:0] root_o
);
  import dcp_pkg::*;

  localparam int unsigned RemW = RootW + 1;

  logic [SumW-1:0]  s_q    [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [SumW-1:0]  s_p;
    logic [RemW-1:0]  rem_p;
    logic [RootW-1:0] root_p;
    logic [RemW+1:0]  rem_t;
    logic [RootW-1:0] root_sh;
    logic [RootW:0]   test;
    logic             ge;
    logic [RemW+1:0]  rem_n;

    if (k == 0) begin : g_first
      assign s_p    = s_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign s_p    = s_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    always_comb begin
      rem_t   = {rem_p, s_p[SumW-1 -: 2]};
      root_sh = {root_p[RootW-2:0], 1'b0};
      test    = {root_sh, 1'b1};
      ge      = rem_t >= {1'b0, test};
      rem_n   = ge ? rem_t - {1'b0, test} : rem_t;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]    <= {s_p[SumW-3:0], 2'b00};
        rem_q[k]  <= rem_n[RemW-1:0];
        root_q[k] <= {root_sh[RootW-1:1], ge};
      end
    end
  end

  assign root_o = root_q[RootW-1];
endmodule

### rtl/dcp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(num * 2^QW / den) for num below den; no package use.
module dcp_div #(
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 30
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] q_o
);
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] quo_p;
    logic [DW:0]   r2;
    logic [DW:0]   rn;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    always_comb begin
      r2 = {rem_p, 1'b0};
      ge = r2 >= {1'b0, den_p};
      rn = ge ? r2 - {1'b0, den_p} : r2;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rn[DW-1:0];
        den_q[k] <= den_p;
        quo_q[k] <= {quo_p[QW-2:0], ge};
      end
    end
  end

  assign q_o = quo_q[QW-1];
endmodule

### rtl/distance_constraint_projection.sv
// Distance constraint projection, fully pipelined.
// Accepts one item per cycle while the output is not stalled.
// Depth is set by the 34-stage square root and the 30-stage fraction divider.
// A stall at the output freezes every stage; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits.
// Depends on dcp_pkg, dcp_in_if, dcp_out_if, dcp_delay, dcp_isqrt, dcp_div.
module distance_constraint_projection (
  input  logic      clk_i,
  input  logic      rst_ni,
  dcp_in_if.sink    in_i,
  dcp_out_if.source out_o
);
  import dcp_pkg::*;

  typedef struct packed {
    logic               v;
    logic signed [31:0] a0, a1, a2, b0, b1, b2;
    logic signed [32:0] d0, d1, d2;
    logic [23:0]        w1, w2;
    logic [30:0]        len;
  } sb1_t;

  typedef struct packed {
    logic               v;
    logic signed [31:0] a0, a1, a2, b0, b1, b2;
    logic signed [32:0] d0, d1, d2;
    logic               fix, w1z, w2z, full;
  } sb2_t;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  sb1_t sb1_d, sb1_q, sb2_q, sb3_q, sbx_in;
  sb2_t sbx_d, sbx_q, sbd_out, sbg_q, sbm_q;
  logic [32:0] mag1_q [3];
  logic [65:0] sq_q   [3];
  logic [SumW-1:0] sum_q;
  logic [RootW-1:0] root;

  always_comb begin
    sb1_d.v   = in_i.valid;
    sb1_d.a0  = in_i.data.first_x;
    sb1_d.a1  = in_i.data.first_y;
    sb1_d.a2  = in_i.data.first_z;
    sb1_d.b0  = in_i.data.second_x;
    sb1_d.b1  = in_i.data.second_y;
    sb1_d.b2  = in_i.data.second_z;
    sb1_d.d0  = 33'(in_i.data.second_x) - 33'(in_i.data.first_x);
    sb1_d.d1  = 33'(in_i.data.second_y) - 33'(in_i.data.first_y);
    sb1_d.d2  = 33'(in_i.data.second_z) - 33'(in_i.data.first_z);
    sb1_d.w1  = in_i.data.first_inv_mass;
    sb1_d.w2  = in_i.data.second_inv_mass;
    sb1_d.len = in_i.data.max_length;
  end

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // capture, square, sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb1_q <= '0;
      sb2_q <= '0;
      sb3_q <= '0;
    end else if (en) begin
      sb1_q <= sb1_d;
      sb2_q <= sb1_q;
      sb3_q <= sb2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q[0] <= mag33(sb1_d.d0);
      mag1_q[1] <= mag33(sb1_d.d1);
      mag1_q[2] <= mag33(sb1_d.d2);
      for (int k = 0; k < 3; k++) sq_q[k] <= mag1_q[k] * mag1_q[k];
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    end
  end

  dcp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (sum_q),
    .root_o (root)
  );

  dcp_delay #(.W($bits(sb1_t)), .N(RootW)) u_dly_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (sb3_q),
    .q_o    (sbx_in)
  );

  // limit check and divider operands
  logic [RootW-1:0] exc_q, dist_q;
  logic [24:0]      tot_q;
  logic [23:0]      w1x_q, w2x_q;

  always_comb begin
    sbx_d.v    = sbx_in.v;
    sbx_d.a0   = sbx_in.a0;
    sbx_d.a1   = sbx_in.a1;
    sbx_d.a2   = sbx_in.a2;
    sbx_d.b0   = sbx_in.b0;
    sbx_d.b1   = sbx_in.b1;
    sbx_d.b2   = sbx_in.b2;
    sbx_d.d0   = sbx_in.d0;
    sbx_d.d1   = sbx_in.d1;
    sbx_d.d2   = sbx_in.d2;
    sbx_d.fix  = (root > RootW'(sbx_in.len)) && ((sbx_in.w1 | sbx_in.w2) != '0);
    sbx_d.w1z  = sbx_in.w1 == '0;
    sbx_d.w2z  = sbx_in.w2 == '0;
    sbx_d.full = sbx_in.len == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbx_q <= '0;
    end else if (en) begin
      sbx_q <= sbx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      exc_q  <= root - RootW'(sbx_in.len);
      dist_q <= root;
      tot_q  <= 25'(sbx_in.w1) + 25'(sbx_in.w2);
      w1x_q  <= sbx_in.w1;
      w2x_q  <= sbx_in.w2;
    end
  end

  logic [FracW-1:0] f, q1, q2;

  dcp_div #(.DW(RootW), .QW(FracW)) u_div_f (
    .clk_i (clk_i), .en_i (en), .num_i (exc_q), .den_i (dist_q), .q_o (f)
  );
  dcp_div #(.DW(25), .QW(FracW)) u_div_s1 (
    .clk_i (clk_i), .en_i (en), .num_i ({1'b0, w1x_q}), .den_i (tot_q), .q_o (q1)
  );
  dcp_div #(.DW(25), .QW(FracW)) u_div_s2 (
    .clk_i (clk_i), .en_i (en), .num_i ({1'b0, w2x_q}), .den_i (tot_q), .q_o (q2)
  );

  dcp_delay #(.W($bits(sb2_t)), .N(FracW)) u_dly_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (sbx_q),
    .q_o    (sbd_out)
  );

  // mass shares, per-particle fraction
  logic [FracW:0]   fr;
  logic [16:0]      s1, s2;
  logic [46:0]      p1, p2;
  logic [FracW:0]   g1_q, g2_q;

  always_comb begin
    fr = sbd_out.full ? {1'b1, {FracW{1'b0}}} : {1'b0, f};
    s1 = sbd_out.w2z ? 17'h10000 : {1'b0, q1[FracW-1 -: 16]};
    s2 = sbd_out.w1z ? 17'h10000 : {1'b0, q2[FracW-1 -: 16]};
    p1 = 47'(fr) * 47'(s1);
    p2 = 47'(fr) * 47'(s2);
  end

  // move per axis
  logic signed [32:0] dg [3];
  logic signed [31:0] ag [3], bg [3];
  logic signed [33:0] mv1_q [3], mv2_q [3];
  logic [62:0]        pm1 [3], pm2 [3];
  logic signed [33:0] mv1 [3], mv2 [3];

  always_comb begin
    dg[0] = sbg_q.d0; dg[1] = sbg_q.d1; dg[2] = sbg_q.d2;
    for (int k = 0; k < 3; k++) begin
      pm1[k] = 63'(mag33(dg[k])) * 63'(g1_q);
      pm2[k] = 63'(mag33(dg[k])) * 63'(g2_q);
      mv1[k] = dg[k][32] ? -$signed({1'b0, pm1[k][62:30]}) : $signed({1'b0, pm1[k][62:30]});
      mv2[k] = dg[k][32] ? -$signed({1'b0, pm2[k][62:30]}) : $signed({1'b0, pm2[k][62:30]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbg_q <= '0;
      sbm_q <= '0;
    end else if (en) begin
      sbg_q <= sbd_out;
      sbm_q <= sbg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= p1[46:16];
      g2_q <= p2[46:16];
      for (int k = 0; k < 3; k++) begin
        mv1_q[k] <= mv1[k];
        mv2_q[k] <= mv2[k];
      end
    end
  end

  // apply, saturate, output register
  out_t res_d, res_q;
  logic vout_q;

  always_comb begin
    ag[0] = sbm_q.a0; ag[1] = sbm_q.a1; ag[2] = sbm_q.a2;
    bg[0] = sbm_q.b0; bg[1] = sbm_q.b1; bg[2] = sbm_q.b2;
    if (sbm_q.fix) begin
      res_d.new_first_x  = sat32(35'(ag[0]) + 35'(mv1_q[0]));
      res_d.new_first_y  = sat32(35'(ag[1]) + 35'(mv1_q[1]));
      res_d.new_first_z  = sat32(35'(ag[2]) + 35'(mv1_q[2]));
      res_d.new_second_x = sat32(35'(bg[0]) - 35'(mv2_q[0]));
      res_d.new_second_y = sat32(35'(bg[1]) - 35'(mv2_q[1]));
      res_d.new_second_z = sat32(35'(bg[2]) - 35'(mv2_q[2]));
    end else begin
      res_d.new_first_x  = ag[0];
      res_d.new_first_y  = ag[1];
      res_d.new_first_z  = ag[2];
      res_d.new_second_x = bg[0];
      res_d.new_second_y = bg[1];
      res_d.new_second_z = bg[2];
    end
    res_d.corrected = sbm_q.fix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= sbm_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = vout_q;
  assign out_o.data  = res_q;
endmodule
